FILE: design/shl_pkg.sv
// ----------------------------------------------------------------------------
// Squared hinge loss package
// Shared constants and the command and status types between the controller
// and the datapath of the squared hinge loss block.
// ----------------------------------------------------------------------------
package shl_pkg;

	// Field widths.
	localparam int SCORE_W  = 16;
	localparam int LABEL_W  = 8;
	localparam int MARGIN_W = 16;
	localparam int GRAD_W   = 24;
	localparam int LOSS_W   = 47;
	localparam int SUM_W    = 48;
	localparam int LSCALE_W = 16;
	localparam int GSCALE_W = 24;
	localparam int CFG_W    = 24;
	localparam int CFG_IDX_W = 2;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_LOSS_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAD_SCALE = 2'd1;

	// Register reset values.
	localparam logic [LSCALE_W-1:0] LOSS_SCALE_RST = 16'd32768;
	localparam logic [GSCALE_W-1:0] GRAD_SCALE_RST = 24'd65536;

	// One in Q4.12, on the sign-extended score width.
	localparam logic signed [SCORE_W+1:0] Q12_ONE = 18'sd4096;

	// Rounding constant for a shift right by 16.
	localparam logic [15:0] RND_HALF = 16'h8000;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;   // capture an input transaction and form the margin
		logic do_mul;    // gradient product and squared margin
		logic do_acc;    // gradient rounding and clamping, sum update
		logic do_lmul;   // partial products of sum times loss scale
		logic do_lfin;   // combine partial products, clamp, clear the sum
		logic load_out;  // move the finished result into the output register
	} shl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last;      // the item in flight closes the batch
	} shl_sts_t;

endpackage

FILE: design/shl_dp.sv
// ----------------------------------------------------------------------------
// Squared hinge loss datapath
// Margin, gradient and loss arithmetic with the configuration registers,
// the loss accumulator and the output payload register.
// ----------------------------------------------------------------------------
module shl_dp
	import shl_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]            cfg_wdata,
	input  logic signed [SCORE_W-1:0]   score,
	input  logic signed [LABEL_W-1:0]   label,
	input  logic                        last,
	input  shl_cmd_t                    cmd,
	output shl_sts_t                    sts,
	output logic signed [GRAD_W-1:0]    gradient,
	output logic [LOSS_W-1:0]           loss,
	output logic                        loss_valid
);

	logic [LSCALE_W-1:0]          loss_scale_q;
	logic [GSCALE_W-1:0]          grad_scale_q;
	logic [SUM_W-1:0]             sum_q;

	logic [MARGIN_W-1:0]          margin_q;
	logic                         neg_q;
	logic                         last_q;
	logic [MARGIN_W+GSCALE_W-1:0] gprod_q;
	logic [2*MARGIN_W-1:0]        sq_q;
	logic [GRAD_W-1:0]            grad_q;
	logic [LSCALE_W+23:0]         pp_lo_q;
	logic [LSCALE_W+23:0]         pp_hi_q;
	logic [LOSS_W-1:0]            loss_q;

	logic signed [SCORE_W+1:0]    score_ext;
	logic [SCORE_W+1:0]           diff_pos;
	logic [SCORE_W+1:0]           diff_neg;
	logic                         label_pos;
	logic                         label_neg;
	logic [MARGIN_W-1:0]          margin_d;
	logic [MARGIN_W+GSCALE_W:0]   rnd;
	logic [GRAD_W:0]              mag;
	logic [GRAD_W:0]              neg_mag;
	logic [GRAD_W-1:0]            grad_d;
	logic [SUM_W:0]               sum_add;
	logic [63:0]                  total;

	assign sts.last = last_q;

	// Margin of the incoming pair; only the sign of the label matters.
	assign score_ext = {{2{score[SCORE_W-1]}}, score};
	assign diff_pos  = Q12_ONE - score_ext;
	assign diff_neg  = score_ext + Q12_ONE;
	assign label_neg = label[LABEL_W-1];
	assign label_pos = !label[LABEL_W-1] && (label != '0);

	always_comb begin
		margin_d = '0;
		if (label_pos && (score_ext < Q12_ONE)) begin
			margin_d = diff_pos[MARGIN_W-1:0];
		end else if (label_neg && (score_ext > -Q12_ONE)) begin
			margin_d = diff_neg[MARGIN_W-1:0];
		end
	end

	// Round half up, then clamp to the signed gradient range.
	assign rnd     = {1'b0, gprod_q} + {{(MARGIN_W+GSCALE_W-15){1'b0}}, RND_HALF};
	assign mag     = rnd[MARGIN_W+GSCALE_W:16];
	assign neg_mag = (GRAD_W+1)'(0) - mag;

	always_comb begin
		if (neg_q) begin
			grad_d = (mag > 25'd8388607) ? 24'h7FFFFF : mag[GRAD_W-1:0];
		end else begin
			grad_d = (mag > 25'd8388608) ? 24'h800000 : neg_mag[GRAD_W-1:0];
		end
	end

	assign sum_add = {1'b0, sum_q} + {{(SUM_W-2*MARGIN_W+1){1'b0}}, sq_q};

	// The full product fits in 64 bits including the rounding term.
	assign total = {pp_hi_q, 24'd0} + {24'd0, pp_lo_q} + {48'd0, RND_HALF};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loss_scale_q <= LOSS_SCALE_RST;
			grad_scale_q <= GRAD_SCALE_RST;
			sum_q        <= '0;
			loss_valid   <= 1'b0;
		end else begin
			if (cfg_we && (cfg_index == CFG_LOSS_SCALE)) begin
				loss_scale_q <= cfg_wdata[LSCALE_W-1:0];
			end
			if (cfg_we && (cfg_index == CFG_GRAD_SCALE)) begin
				grad_scale_q <= cfg_wdata[GSCALE_W-1:0];
			end
			if (cmd.do_acc) begin
				sum_q <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
			end else if (cmd.do_lfin) begin
				sum_q <= '0;
			end
			if (cmd.load_out) begin
				loss_valid <= last_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			margin_q <= margin_d;
			neg_q    <= label_neg;
			last_q   <= last;
		end
		if (cmd.do_mul) begin
			gprod_q <= margin_q * grad_scale_q;
			sq_q    <= margin_q * margin_q;
		end
		if (cmd.do_acc) begin
			grad_q <= grad_d;
		end
		if (cmd.do_lmul) begin
			pp_lo_q <= sum_q[23:0] * loss_scale_q;
			pp_hi_q <= sum_q[SUM_W-1:24] * loss_scale_q;
		end
		if (cmd.do_lfin) begin
			loss_q <= total[63] ? '1 : total[62:16];
		end
		if (cmd.load_out) begin
			gradient <= grad_q;
			loss     <= last_q ? loss_q : '0;
		end
	end

	// The accumulator is empty once a batch loss has been formed.
	a_sum_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_lfin |=> (sum_q == '0))
		else $error("loss sum not cleared after batch loss");

	// A result that does not close a batch carries a zero loss.
	a_loss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_out && !last_q) |=> (!loss_valid && (loss == '0)))
		else $error("loss given out on an item that is not last");

endmodule

FILE: design/shl_ctrl.sv
// ----------------------------------------------------------------------------
// Squared hinge loss controller
// Sequences one item through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module shl_ctrl
	import shl_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  shl_sts_t sts,
	output shl_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_ACC,
		S_LMUL,
		S_LFIN,
		S_PUSH
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load_in  = (state_q == S_IDLE) && in_valid;
		cmd.do_mul   = (state_q == S_MUL);
		cmd.do_acc   = (state_q == S_ACC);
		cmd.do_lmul  = (state_q == S_LMUL);
		cmd.do_lfin  = (state_q == S_LFIN);
		cmd.load_out = (state_q == S_PUSH) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					state_q <= sts.last ? S_LMUL : S_PUSH;
				end
				S_LMUL: begin
					state_q <= S_LFIN;
				end
				S_LFIN: begin
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Only one item is in flight at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second transaction accepted while busy");

	// A pending result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result register loaded while still full");

	// The loss sequence runs only for the item that closes a batch.
	a_loss_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.do_lmul || cmd.do_lfin) |-> sts.last)
		else $error("batch loss formed for an item that is not last");

endmodule

FILE: design/squared_hinge_loss_and_gradient.sv
// ----------------------------------------------------------------------------
// Squared hinge loss and gradient
// Streams score and label pairs and returns the gradient of each item and,
// on the last item of a batch, the scaled squared hinge loss.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) carries one score, label and
// last flag per transaction; the output channel (out_valid/out_ready)
// returns exactly one gradient, loss and loss_valid per input transaction.
// A zero label yields a zero gradient and does not touch the loss sum.
// The block holds one item at a time. An ordinary item raises out_valid
// after these steps: the margin is captured at the edge that accepts it,
// then come the two multiplies, the rounding and accumulation, and the output
// load. The item flagged last also goes through the loss product,
// which is split into two 24 by 16 bit partial products and combined in a
// following cycle. The next item can be accepted in the cycle after the
// result is loaded; none is taken while an item is still in these steps.
// The result sits in an output register; a new item is accepted while it
// waits, and if the receiver stalls the block halts before loading the next
// result until that register is free.
// Reset clears the loss sum and the handshake state and sets loss_scale to
// 1/2 and grad_scale to 1.0. Configuration writes (cfg_we, cfg_index,
// cfg_wdata) take effect at once and are expected only while idle.
// ----------------------------------------------------------------------------
module squared_hinge_loss_and_gradient
	import shl_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]            cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [SCORE_W-1:0]   score,
	input  logic signed [LABEL_W-1:0]   label,
	input  logic                        last,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [GRAD_W-1:0]    gradient,
	output logic [LOSS_W-1:0]           loss,
	output logic                        loss_valid
);

	// Command and status between the sequencer and the arithmetic.
	shl_cmd_t cmd;
	shl_sts_t sts;

	// The controller owns both handshakes and steps each item through.
	shl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the registers, the accumulator and the result.
	shl_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.score      (score),
		.label      (label),
		.last       (last),
		.cmd        (cmd),
		.sts        (sts),
		.gradient   (gradient),
		.loss       (loss),
		.loss_valid (loss_valid)
	);

endmodule
